### hw/rtl/lis_pkg.sv
// shared sizes for the longest increasing subsequence block
package lis_pkg;
  localparam int unsigned MaxItems = 64;
  localparam int unsigned IdxW     = $clog2(MaxItems);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned ValW     = 32;
  localparam int unsigned LenW     = 7;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic signed [ValW-1:0] val_t;
endpackage

### hw/rtl/longest_increasing_subsequence.sv
// longest strictly increasing subsequence by patience sorting
// a non-final item runs s binary search steps in the shared tail compare loop
//   (s <= ceil(log2(piles+1)) <= 7), then the pile update
// a final item adds the predecessor walk and then n transfers,
//   one emit buffer read per element, n = result length
// throughput: one item in flight; in_stall_o is high until the item is fully handled
// reset: asynchronous, active low; clears control and counts, memories hold no reset
module longest_increasing_subsequence (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [lis_pkg::ValW-1:0]  sample_value_i,
  input  logic                             end_of_sequence_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [lis_pkg::ValW-1:0]  sub_value_o,
  output logic [lis_pkg::LenW-1:0]         sub_length_o,
  output logic                             final_item_o,
  output logic                             capacity_exceeded_o
);

  // sequencer codes
  localparam logic [3:0] StIdle  = 4'd0;  // waiting for an input transfer
  localparam logic [3:0] StSrch  = 4'd1;  // issue tail read for next search step
  localparam logic [3:0] StCmp   = 4'd2;  // compare tail against the new value
  localparam logic [3:0] StUpd   = 4'd3;  // equality check and pile update
  localparam logic [3:0] StWTail = 4'd4;  // read tail index of the rightmost pile
  localparam logic [3:0] StWSet  = 4'd5;  // load walk pointer
  localparam logic [3:0] StWRd   = 4'd6;  // read value and link at walk pointer
  localparam logic [3:0] StWWr   = 4'd7;  // store element into emit buffer
  localparam logic [3:0] StERd   = 4'd8;  // read emit buffer entry
  localparam logic [3:0] StEOut  = 4'd9;  // hand entry to the output register

  logic [3:0] st_q, st_d;

  // item and search registers
  lis_pkg::val_t val_q, val_d;
  logic          eos_q, eos_d;
  lis_pkg::idx_t idx_q, idx_d;
  lis_pkg::cnt_t lo_q, lo_d, hi_q, hi_d;
  lis_pkg::cnt_t cnt_q, cnt_d;      // number of piles
  lis_pkg::cnt_t items_q, items_d;  // values stored this sequence
  logic          ovf_q, ovf_d;
  lis_pkg::cnt_t k_q, k_d;          // walk and emit position
  lis_pkg::idx_t cur_q, cur_d;      // walk pointer

  // output register
  logic                           ov_q, ov_d;
  lis_pkg::val_t                  ovalue_q, ovalue_d;
  logic [lis_pkg::LenW-1:0]       olen_q, olen_d;
  logic                           ofinal_q, ofinal_d;
  logic                           oovf_q, oovf_d;

  // memories
  lis_pkg::val_t vs_mem   [lis_pkg::MaxItems];  // every stored value
  lis_pkg::idx_t pred_mem [lis_pkg::MaxItems];  // predecessor link per value
  lis_pkg::idx_t tidx_mem [lis_pkg::MaxItems];  // value index of each pile tail
  lis_pkg::val_t tval_mem [lis_pkg::MaxItems];  // copy of each pile tail value
  lis_pkg::val_t emit_mem [lis_pkg::MaxItems];  // subsequence in forward order

  lis_pkg::val_t vs_rd_q, tval_rd_q, emit_rd_q;
  lis_pkg::idx_t pred_rd_q, tidx_rd_q;

  logic          vs_we, upd_we, emit_we;
  lis_pkg::idx_t tval_ra, tidx_ra;

  logic [lis_pkg::CntW:0] mid_sum;
  lis_pkg::cnt_t          mid;
  logic                   accept, slot_free, is_equal;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle);
  assign slot_free = !ov_q || !out_stall_i;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[lis_pkg::CntW:1];

  // tail value port: search midpoint while searching, final position once lo meets hi
  assign tval_ra = (lo_q < hi_q) ? mid[lis_pkg::IdxW-1:0] : lo_q[lis_pkg::IdxW-1:0];

  // tail index port: left neighbor's tail for the link, or the rightmost tail for the walk
  always_comb begin
    if (st_q == StWTail) begin
      tidx_ra = lis_pkg::IdxW'(cnt_q - lis_pkg::CntW'(1));
    end else begin
      tidx_ra = lis_pkg::IdxW'(lo_q - lis_pkg::CntW'(1));
    end
  end

  // value equal to an existing tail is dropped to keep the sequence strict
  assign is_equal = (lo_q < cnt_q) && (tval_rd_q == val_q);

  always_comb begin
    st_d     = st_q;
    val_d    = val_q;
    eos_d    = eos_q;
    idx_d    = idx_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    cnt_d    = cnt_q;
    items_d  = items_q;
    ovf_d    = ovf_q;
    k_d      = k_q;
    cur_d    = cur_q;
    ov_d     = ov_q && out_stall_i;
    ovalue_d = ovalue_q;
    olen_d   = olen_q;
    ofinal_d = ofinal_q;
    oovf_d   = oovf_q;
    vs_we    = 1'b0;
    upd_we   = 1'b0;
    emit_we  = 1'b0;

    case (st_q)
      StIdle: begin
        if (accept) begin
          eos_d = end_of_sequence_i;
          if (items_q < lis_pkg::CntW'(lis_pkg::MaxItems)) begin
            vs_we   = 1'b1;
            val_d   = sample_value_i;
            idx_d   = items_q[lis_pkg::IdxW-1:0];
            items_d = items_q + lis_pkg::CntW'(1);
            lo_d    = '0;
            hi_d    = cnt_q;
            st_d    = StSrch;
          end else begin
            // beyond capacity: value ignored, a final item still emits
            ovf_d = 1'b1;
            if (end_of_sequence_i) begin
              st_d = StWTail;
            end
          end
        end
      end
      StSrch: begin
        st_d = (lo_q < hi_q) ? StCmp : StUpd;
      end
      StCmp: begin
        // lower bound: move past tails that are strictly smaller
        if (tval_rd_q < val_q) begin
          lo_d = mid + lis_pkg::CntW'(1);
        end else begin
          hi_d = mid;
        end
        st_d = StSrch;
      end
      StUpd: begin
        if (!is_equal) begin
          upd_we = 1'b1;
          if (lo_q == cnt_q) begin
            cnt_d = cnt_q + lis_pkg::CntW'(1);
          end
        end
        st_d = eos_q ? StWTail : StIdle;
      end
      StWTail: begin
        k_d  = cnt_q;
        st_d = StWSet;
      end
      StWSet: begin
        cur_d = tidx_rd_q;
        st_d  = StWRd;
      end
      StWRd: begin
        st_d = StWWr;
      end
      StWWr: begin
        // walk runs backward, so the buffer fills from the end
        emit_we = 1'b1;
        cur_d   = pred_rd_q;
        k_d     = k_q - lis_pkg::CntW'(1);
        st_d    = (k_q == lis_pkg::CntW'(1)) ? StERd : StWRd;
      end
      StERd: begin
        st_d = StEOut;
      end
      StEOut: begin
        if (slot_free) begin
          ov_d     = 1'b1;
          ovalue_d = emit_rd_q;
          olen_d   = lis_pkg::LenW'(cnt_q);
          ofinal_d = (k_q + lis_pkg::CntW'(1) == cnt_q);
          oovf_d   = ovf_q;
          k_d      = k_q + lis_pkg::CntW'(1);
          if (k_q + lis_pkg::CntW'(1) == cnt_q) begin
            // sequence done, next item opens a new one
            cnt_d   = '0;
            items_d = '0;
            ovf_d   = 1'b0;
            st_d    = StIdle;
          end else begin
            st_d = StERd;
          end
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      cnt_q   <= '0;
      items_q <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
      eos_q   <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      k_q     <= '0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      items_q <= items_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
      eos_q   <= eos_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      k_q     <= k_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    idx_q    <= idx_d;
    cur_q    <= cur_d;
    ovalue_q <= ovalue_d;
    olen_q   <= olen_d;
    ofinal_q <= ofinal_d;
    oovf_q   <= oovf_d;
  end

  // value store
  always_ff @(posedge clk_i) begin
    if (vs_we) begin
      vs_mem[items_q[lis_pkg::IdxW-1:0]] <= sample_value_i;
    end
    vs_rd_q <= vs_mem[cur_q];
  end

  // predecessor links
  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      pred_mem[idx_q] <= (lo_q == '0) ? '0 : tidx_rd_q;
    end
    pred_rd_q <= pred_mem[cur_q];
  end

  // pile tail indexes
  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      tidx_mem[lo_q[lis_pkg::IdxW-1:0]] <= idx_q;
    end
    tidx_rd_q <= tidx_mem[tidx_ra];
  end

  // pile tail values
  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      tval_mem[lo_q[lis_pkg::IdxW-1:0]] <= val_q;
    end
    tval_rd_q <= tval_mem[tval_ra];
  end

  // emit buffer
  always_ff @(posedge clk_i) begin
    if (emit_we) begin
      emit_mem[lis_pkg::IdxW'(k_q - lis_pkg::CntW'(1))] <= vs_rd_q;
    end
    emit_rd_q <= emit_mem[k_q[lis_pkg::IdxW-1:0]];
  end

  assign out_valid_o         = ov_q;
  assign sub_value_o         = ovalue_q;
  assign sub_length_o        = olen_q;
  assign final_item_o        = ofinal_q;
  assign capacity_exceeded_o = oovf_q;

  // piles never outnumber stored values
  a_piles_le_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= items_q)
    else $error("pile count above stored item count");

  // store never fills past capacity
  a_items_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= lis_pkg::CntW'(lis_pkg::MaxItems))
    else $error("stored item count beyond capacity");

  // search window stays ordered and inside the pile range
  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StSrch || st_q == StCmp) |-> (lo_q <= hi_q && hi_q <= cnt_q))
    else $error("search bounds out of order");

  // a presented result always carries a nonzero length
  a_out_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sub_length_o != '0))
    else $error("result with zero length");
endmodule
